// ----- sv/lcdseq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_pkg
// shared types, codes and constants of the character lcd nibble sequencer
// ----------------------------------------------------------------------------
package lcdseq_pkg;

   // command codes of the request channel
   localparam logic [2:0] CMD_INIT   = 3'd0;
   localparam logic [2:0] CMD_WRITE  = 3'd1;
   localparam logic [2:0] CMD_CLEAR  = 3'd2;
   localparam logic [2:0] CMD_HOME   = 3'd3;
   localparam logic [2:0] CMD_CURSOR = 3'd4;
   localparam logic [2:0] CMD_GLYPH  = 3'd5;

   // csr indexes
   localparam logic [2:0] CSR_VISIBLE_COLUMNS  = 3'd0;
   localparam logic [2:0] CSR_ROW_LENGTH       = 3'd1;
   localparam logic [2:0] CSR_SECOND_ROW_START = 3'd2;
   localparam logic [2:0] CSR_COMMAND_WAIT     = 3'd3;
   localparam logic [2:0] CSR_CLEAR_WAIT       = 3'd4;

   // special characters
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_RETURN  = 8'h0D;

   // controller instruction bytes
   localparam logic [7:0] INSTR_CLEAR    = 8'h01;
   localparam logic [7:0] INSTR_HOME     = 8'h02;
   localparam logic [7:0] INSTR_ENTRY    = 8'h06;
   localparam logic [7:0] INSTR_DISPLAY  = 8'h0C;
   localparam logic [7:0] INSTR_FUNCTION = 8'h28;
   localparam logic [7:0] INSTR_SET_DDRAM = 8'h80;
   localparam logic [1:0] INSTR_SET_CGRAM_HI = 2'b01;

   // wake-up nibbles and waits
   localparam logic [3:0]  NIB_WAKE      = 4'h3;
   localparam logic [3:0]  NIB_FOUR_BIT  = 4'h2;
   localparam logic [15:0] WAIT_POWER_UP = 16'd50000;
   localparam logic [15:0] WAIT_WAKE_1   = 16'd5000;
   localparam logic [15:0] WAIT_WAKE_2   = 16'd150;
   localparam logic [15:0] WAIT_FOUR_BIT = 16'd50;

   // reset values of the csrs
   localparam logic [5:0]  RST_VISIBLE_COLUMNS  = 6'd16;
   localparam logic [6:0]  RST_ROW_LENGTH       = 7'd40;
   localparam logic [6:0]  RST_SECOND_ROW_START = 7'd64;
   localparam logic [15:0] RST_COMMAND_WAIT     = 16'd50;
   localparam logic [15:0] RST_CLEAR_WAIT       = 16'd2000;

   localparam int QUEUE_DEPTH = 2;

   // what the back end has to play out
   typedef enum logic [1:0] {
      OP_INIT,
      OP_BYTE,
      OP_CLEAR,
      OP_GLYPH
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  value;   // byte, clear/home code, or ddram restore byte
      logic        rs;
      logic [2:0]  slot;
      logic [63:0] glyph;
   } job_type;

   typedef struct packed {
      logic [5:0]  visible_columns;
      logic [6:0]  row_length;
      logic [6:0]  second_row_start;
      logic [15:0] command_wait_us;
      logic [15:0] clear_wait_us;
   } cfg_type;

endpackage
`default_nettype wire

// ----- sv/lcdseq_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_front
// accepts commands, tracks the display address and queues transfer jobs
// ----------------------------------------------------------------------------
module lcdseq_front
   import lcdseq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic [7:0]  req_character,
   input  wire logic [7:0]  req_column,
   input  wire logic [7:0]  req_row,
   input  wire logic [2:0]  req_glyph_slot,
   input  wire logic [31:0] req_glyph_rows_low,
   input  wire logic [31:0] req_glyph_rows_high,
   input  wire logic        queue_full,
   output logic             push,
   output job_type          job
);

   logic [6:0] address_ff, address_in;
   logic       accept, has_job;
   logic [6:0] next_addr, target;
   logic [7:0] end2, limit, col;
   logic [6:0] base;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept && has_job;

   always_comb begin
      next_addr = address_ff + 7'd1;
      end2      = {1'b0, cfg.second_row_start} + {1'b0, cfg.row_length};
      limit     = (cfg.visible_columns == 6'd0) ? 8'd0 : {2'b00, cfg.visible_columns} - 8'd1;
      col       = (req_column < {2'b00, cfg.visible_columns}) ? req_column : limit;
      base      = (req_row == 8'd0) ? 7'd0 : cfg.second_row_start;
      target    = base + col[6:0];

      has_job   = 1'b1;
      address_in = address_ff;
      job.op    = OP_BYTE;
      job.value = 8'd0;
      job.rs    = 1'b0;
      job.slot  = req_glyph_slot;
      job.glyph = {req_glyph_rows_high, req_glyph_rows_low};

      unique case (req_command)
         CMD_INIT: begin
            job.op     = OP_INIT;
            address_in = 7'd0;
         end
         CMD_WRITE: begin
            if (req_character == CHAR_NEWLINE) begin
               address_in = (address_ff < cfg.second_row_start) ? cfg.second_row_start : 7'd0;
               job.value  = INSTR_SET_DDRAM | {1'b0, address_in};
            end else if (req_character == CHAR_RETURN) begin
               has_job = 1'b0;
            end else begin
               job.value = req_character;
               job.rs    = 1'b1;
               if (next_addr == cfg.row_length)
                  address_in = cfg.second_row_start;
               else if ({1'b0, next_addr} == end2)
                  address_in = 7'd0;
               else
                  address_in = next_addr;
            end
         end
         CMD_CLEAR, CMD_HOME: begin
            job.op     = OP_CLEAR;
            job.value  = (req_command == CMD_CLEAR) ? INSTR_CLEAR : INSTR_HOME;
            address_in = 7'd0;
         end
         CMD_CURSOR: begin
            address_in = target;
            job.value  = INSTR_SET_DDRAM | {1'b0, target};
         end
         CMD_GLYPH: begin
            job.op    = OP_GLYPH;
            job.value = INSTR_SET_DDRAM | {1'b0, address_ff};
         end
         default: has_job = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         address_ff <= 7'd0;
      else if (accept)
         address_ff <= address_in;
   end

endmodule
`default_nettype wire

// ----- sv/lcdseq_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_queue
// short job fifo between the front and back ends
// ----------------------------------------------------------------------------
module lcdseq_queue
   import lcdseq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head,
   output logic         empty,
   output logic         full
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type        slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]  count_ff, count_in;

   assign empty = (count_ff == CW'(0));
   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign head  = slots_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push)
         wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : wr_ff + PW'(1);
      if (pop)
         rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? PW'(0) : rd_ff + PW'(1);
      if (push && !pop)
         count_in = count_ff + CW'(1);
      else if (pop && !push)
         count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slots_ff[wr_ff] <= push_job;
   end

endmodule
`default_nettype wire

// ----- sv/lcdseq_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_back
// plays a queued job out as nibble transfers, one per cycle while not stalled
// ----------------------------------------------------------------------------
module lcdseq_back
   import lcdseq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire job_type head,
   input  wire logic    empty,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic         rsp_strobe_res,
   output logic         rsp_register_select,
   output logic [3:0]   rsp_nibble,
   output logic [15:0]  rsp_wait_after_us,
   output logic         rsp_last
);

   logic [4:0]  step_ff, step_in;
   logic        valid_ff, valid_in;
   logic        strobe_ff, rs_ff, last_ff;
   logic [3:0]  nib_ff;
   logic [15:0] wait_ff;

   logic        load;
   logic        strobe, rs, last, use_byte, hi;
   logic [3:0]  nib;
   logic [15:0] wait_us;
   logic [7:0]  byte_val;
   logic [2:0]  gidx;
   logic [3:0]  gsel;

   assign load = !empty && (!valid_ff || !rsp_stall);
   assign pop  = load && last;

   always_comb begin
      gsel     = step_ff[4:1] - 4'd1;
      gidx     = gsel[2:0];
      strobe   = 1'b1;
      rs       = 1'b0;
      last     = 1'b0;
      use_byte = 1'b1;
      hi       = !step_ff[0];
      byte_val = head.value;
      nib      = 4'd0;
      wait_us  = 16'd0;

      unique case (head.op)
         OP_INIT: begin
            hi = step_ff[0];
            unique case (step_ff)
               5'd0: begin
                  use_byte = 1'b0;
                  strobe   = 1'b0;
                  wait_us  = WAIT_POWER_UP;
               end
               5'd1: begin
                  use_byte = 1'b0;
                  nib      = NIB_WAKE;
                  wait_us  = WAIT_WAKE_1;
               end
               5'd2, 5'd3: begin
                  use_byte = 1'b0;
                  nib      = NIB_WAKE;
                  wait_us  = WAIT_WAKE_2;
               end
               5'd4: begin
                  use_byte = 1'b0;
                  nib      = NIB_FOUR_BIT;
                  wait_us  = WAIT_FOUR_BIT;
               end
               5'd5, 5'd6: byte_val = INSTR_FUNCTION;
               5'd7, 5'd8: byte_val = INSTR_DISPLAY;
               5'd9, 5'd10: byte_val = INSTR_CLEAR;
               5'd11: begin
                  use_byte = 1'b0;
                  strobe   = 1'b0;
                  wait_us  = cfg.clear_wait_us;
               end
               default: begin
                  // the wait-only step shifts the nibble phase back to even
                  hi       = !step_ff[0];
                  byte_val = INSTR_ENTRY;
                  last     = (step_ff == 5'd13);
               end
            endcase
         end
         OP_BYTE: begin
            rs   = head.rs;
            last = (step_ff == 5'd1);
         end
         OP_CLEAR: begin
            if (step_ff == 5'd2) begin
               use_byte = 1'b0;
               strobe   = 1'b0;
               wait_us  = cfg.clear_wait_us;
               last     = 1'b1;
            end
         end
         OP_GLYPH: begin
            if (step_ff < 5'd2) begin
               byte_val = {INSTR_SET_CGRAM_HI, head.slot, 3'b000};
            end else if (step_ff < 5'd18) begin
               byte_val = head.glyph[{gidx, 3'b000} +: 8];
               rs       = 1'b1;
            end
            last = (step_ff == 5'd19);
         end
      endcase

      if (use_byte) begin
         nib     = hi ? byte_val[7:4] : byte_val[3:0];
         wait_us = hi ? 16'd0 : cfg.command_wait_us;
      end

      step_in = step_ff;
      if (load)
         step_in = last ? 5'd0 : step_ff + 5'd1;

      valid_in = valid_ff && rsp_stall;
      if (load)
         valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 5'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         strobe_ff <= strobe;
         rs_ff     <= rs;
         nib_ff    <= nib;
         wait_ff   <= wait_us;
         last_ff   <= last;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_strobe_res      = strobe_ff;
   assign rsp_register_select = rs_ff;
   assign rsp_nibble          = nib_ff;
   assign rsp_wait_after_us   = wait_ff;
   assign rsp_last            = last_ff;

endmodule
`default_nettype wire

// ----- sv/char_lcd_nibble_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// turns character lcd commands into 4-bit bus transfers, high nibble first
// ----------------------------------------------------------------------------
// usage:
//  - req_* carries one command per transaction (valid/stall); it is taken
//    whenever the job queue has room, so commands arrive back to back
//  - rsp_* gives one transfer per transaction: strobe or wait-only, rs,
//    nibble, wait time and a last flag on the final transfer of a command
//  - csr_* writes the five config registers (index, data); csr_ready is
//    always high, write only while the block is idle
// path: a taken command is written into the job queue, then its first
//  transfer goes through the back end's output register to rsp
// throughput: the back end emits one transfer per cycle while rsp_stall is
//  low and a job is queued; a command gives 2 transfers for a character or
//  cursor move, 3 for clear/home, 14 for initialise, 20 for define glyph;
//  carriage return and unused codes take no back-end time
// reset: config returns to its defaults, display address goes to 0, the
//  queue and output register empty
// stall: while rsp_stall is high the output register holds its transfer;
//  the queue fills and then req_stall goes high
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer
   import lcdseq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic [7:0]  req_character,
   input  wire logic [7:0]  req_column,
   input  wire logic [7:0]  req_row,
   input  wire logic [2:0]  req_glyph_slot,
   input  wire logic [31:0] req_glyph_rows_low,
   input  wire logic [31:0] req_glyph_rows_high,
   // transfer channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_strobe_res,
   output logic             rsp_register_select,
   output logic [3:0]       rsp_nibble,
   output logic [15:0]      rsp_wait_after_us,
   output logic             rsp_last,
   // config write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   cfg_type cfg_ff;
   job_type push_job, head;
   logic    push, pop, empty, full;

   // config registers; the user must write them only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.visible_columns  <= RST_VISIBLE_COLUMNS;
         cfg_ff.row_length       <= RST_ROW_LENGTH;
         cfg_ff.second_row_start <= RST_SECOND_ROW_START;
         cfg_ff.command_wait_us  <= RST_COMMAND_WAIT;
         cfg_ff.clear_wait_us    <= RST_CLEAR_WAIT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VISIBLE_COLUMNS:  cfg_ff.visible_columns  <= csr_data[5:0];
            CSR_ROW_LENGTH:       cfg_ff.row_length       <= csr_data[6:0];
            CSR_SECOND_ROW_START: cfg_ff.second_row_start <= csr_data[6:0];
            CSR_COMMAND_WAIT:     cfg_ff.command_wait_us  <= csr_data;
            CSR_CLEAR_WAIT:       cfg_ff.clear_wait_us    <= csr_data;
            default: ;  // writes beyond the list are dropped
         endcase
      end
   end

   // front: classify commands, keep the display address
   lcdseq_front u_front (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_character       (req_character),
      .req_column          (req_column),
      .req_row             (req_row),
      .req_glyph_slot      (req_glyph_slot),
      .req_glyph_rows_low  (req_glyph_rows_low),
      .req_glyph_rows_high (req_glyph_rows_high),
      .queue_full          (full),
      .push                (push),
      .job                 (push_job)
   );

   // job queue decouples the two sides
   lcdseq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   // back: sequence the transfers of the head job
   lcdseq_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .head                (head),
      .empty               (empty),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_strobe_res      (rsp_strobe_res),
      .rsp_register_select (rsp_register_select),
      .rsp_nibble          (rsp_nibble),
      .rsp_wait_after_us   (rsp_wait_after_us),
      .rsp_last            (rsp_last)
   );

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives character lcd commands into the nibble sequencer and checks every
// 4-bit bus transfer it plays out against an in-bench expansion of each
// command, across several register settings and idle/stall patterns
// ----------------------------------------------------------------------------
module testbench;
   import lcdseq_pkg::*;

   // command codes the block must ignore
   localparam logic [2:0] CMD_RESERVED_6 = 3'd6;
   localparam logic [2:0] CMD_RESERVED_7 = 3'd7;

   localparam int DRAIN_CYCLES = 8;     // margin for commands still in the block's registers
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int STALL_LIMIT  = 2000;  // cycles with no transaction at all

   typedef struct {
      logic [2:0]  cmd;
      logic [7:0]  character;
      logic [7:0]  column;
      logic [7:0]  row;
      logic [2:0]  slot;
      logic [31:0] rows_low;
      logic [31:0] rows_high;
   } lcd_command_type;

   typedef struct {
      logic        strobe;
      logic        rs;
      logic [3:0]  nibble;
      logic [15:0] wait_us;
      logic        last;
   } lcd_transfer_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   // block inputs, all known from time zero
   logic        req_valid           = 1'b0;
   logic [2:0]  req_command         = '0;
   logic [7:0]  req_character       = '0;
   logic [7:0]  req_column          = '0;
   logic [7:0]  req_row             = '0;
   logic [2:0]  req_glyph_slot      = '0;
   logic [31:0] req_glyph_rows_low  = '0;
   logic [31:0] req_glyph_rows_high = '0;
   logic        rsp_stall           = 1'b0;
   logic        csr_valid           = 1'b0;
   logic [2:0]  csr_index           = '0;
   logic [15:0] csr_data            = '0;

   // block outputs
   wire logic        req_stall;
   wire logic        rsp_valid;
   wire logic        rsp_strobe_res;
   wire logic        rsp_register_select;
   wire logic [3:0]  rsp_nibble;
   wire logic [15:0] rsp_wait_after_us;
   wire logic        rsp_last;
   wire logic        csr_ready;

   char_lcd_nibble_sequencer dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_character       (req_character),
      .req_column          (req_column),
      .req_row             (req_row),
      .req_glyph_slot      (req_glyph_slot),
      .req_glyph_rows_low  (req_glyph_rows_low),
      .req_glyph_rows_high (req_glyph_rows_high),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_strobe_res      (rsp_strobe_res),
      .rsp_register_select (rsp_register_select),
      .rsp_nibble          (rsp_nibble),
      .rsp_wait_after_us   (rsp_wait_after_us),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // commands waiting to be driven, transfers waiting to be seen
   lcd_command_type  pending_cmds[$];
   lcd_transfer_type expected_transfers[$];

   // shadow of the block's registers and display address
   cfg_type    lcd_cfg = '{visible_columns: RST_VISIBLE_COLUMNS,
                           row_length: RST_ROW_LENGTH,
                           second_row_start: RST_SECOND_ROW_START,
                           command_wait_us: RST_COMMAND_WAIT,
                           clear_wait_us: RST_CLEAR_WAIT};
   logic [6:0] shadow_address = '0;

   // idling percentages, set per phase by the sequence below
   int send_idle_pct = 27;
   int recv_idle_pct = 80;

   // long hold-off requests and how many the stall process has served
   int hold_wanted = 0;
   int hold_served = 0;
   int hold_left   = 0;

   // handshake flags, refreshed at every rising edge
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   logic csr_taken = 1'b0;

   int quiet_cycles = 0;
   int mismatches   = 0;
   int transfers_checked = 0;
   int cmd_count[8];
   int settings_used = 0;

   lcd_command_type  drive_cmd;
   lcd_command_type  taken_cmd;
   lcd_transfer_type seen;
   lcd_transfer_type want;

   // -------------------------------------------------------------------------
   // mismatch reporting: one line and a count
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h (transfer %0d)",
               $realtime, what, got, exp_val, transfers_checked);
      mismatches++;
   endtask

   // -------------------------------------------------------------------------
   // expansion of commands into expected transfers
   // -------------------------------------------------------------------------
   task automatic push_transfer(input logic strobe, input logic rs,
                                input logic [3:0] nib, input logic [15:0] wait_us);
      lcd_transfer_type t;
      t.strobe  = strobe;
      t.rs      = rs;
      t.nibble  = nib;
      t.wait_us = wait_us;
      t.last    = 1'b0;
      expected_transfers.push_back(t);
   endtask

   // a full byte goes high nibble first, only the low nibble carries the wait
   task automatic push_byte(input logic [7:0] value, input logic rs);
      push_transfer(1'b1, rs, value[7:4], 16'd0);
      push_transfer(1'b1, rs, value[3:0], lcd_cfg.command_wait_us);
   endtask

   task automatic push_address_set(input logic [6:0] addr);
      push_byte(INSTR_SET_DDRAM | {1'b0, addr}, 1'b0);
      shadow_address = addr;
   endtask

   // clear or home: the byte, then a wait-only transfer
   task automatic push_clear_or_home(input logic [7:0] code);
      push_byte(code, 1'b0);
      push_transfer(1'b0, 1'b0, 4'h0, lcd_cfg.clear_wait_us);
      shadow_address = '0;
   endtask

   task automatic expand_command(input lcd_command_type c);
      int               depth_before;
      logic [6:0]       next_addr;
      logic [7:0]       row_one_end;
      int               clamp_limit;
      int               col;
      int               addr_sum;
      lcd_transfer_type tail;
      depth_before = expected_transfers.size();
      case (c.cmd)
         CMD_INIT: begin
            push_transfer(1'b0, 1'b0, 4'h0, WAIT_POWER_UP);
            push_transfer(1'b1, 1'b0, NIB_WAKE, WAIT_WAKE_1);
            push_transfer(1'b1, 1'b0, NIB_WAKE, WAIT_WAKE_2);
            push_transfer(1'b1, 1'b0, NIB_WAKE, WAIT_WAKE_2);
            push_transfer(1'b1, 1'b0, NIB_FOUR_BIT, WAIT_FOUR_BIT);
            push_byte(INSTR_FUNCTION, 1'b0);
            push_byte(INSTR_DISPLAY, 1'b0);
            push_clear_or_home(INSTR_CLEAR);
            push_byte(INSTR_ENTRY, 1'b0);
         end
         CMD_WRITE: begin
            if (c.character == CHAR_NEWLINE) begin
               // newline toggles between the two rows
               push_address_set(shadow_address < lcd_cfg.second_row_start ?
                                lcd_cfg.second_row_start : 7'd0);
            end else if (c.character != CHAR_RETURN) begin
               next_addr   = shadow_address + 7'd1;
               row_one_end = {1'b0, lcd_cfg.second_row_start} +
                             {1'b0, lcd_cfg.row_length};
               push_byte(c.character, 1'b1);
               // end of row zero wins over end of row one
               if (next_addr == lcd_cfg.row_length)
                  next_addr = lcd_cfg.second_row_start;
               else if ({1'b0, next_addr} == row_one_end)
                  next_addr = '0;
               shadow_address = next_addr;
            end
         end
         CMD_CLEAR: push_clear_or_home(INSTR_CLEAR);
         CMD_HOME:  push_clear_or_home(INSTR_HOME);
         CMD_CURSOR: begin
            // zero visible columns saturates the clamp at column zero
            clamp_limit = (lcd_cfg.visible_columns == 0) ? 0 :
                          int'(lcd_cfg.visible_columns) - 1;
            col = (c.column < lcd_cfg.visible_columns) ? int'(c.column) : clamp_limit;
            addr_sum = ((c.row == 8'd0) ? 0 : int'(lcd_cfg.second_row_start)) + col;
            push_address_set(addr_sum[6:0]);
         end
         CMD_GLYPH: begin
            push_byte({INSTR_SET_CGRAM_HI, c.slot, 3'b000}, 1'b0);
            for (int i = 0; i < 4; i++) push_byte(c.rows_low[8*i +: 8], 1'b1);
            for (int i = 0; i < 4; i++) push_byte(c.rows_high[8*i +: 8], 1'b1);
            // back to display memory at the unchanged address
            push_address_set(shadow_address);
         end
         default: ;
      endcase
      if (expected_transfers.size() > depth_before) begin
         tail = expected_transfers.pop_back();
         tail.last = 1'b1;
         expected_transfers.push_back(tail);
      end
   endtask

   // -------------------------------------------------------------------------
   // stimulus helpers
   // -------------------------------------------------------------------------
   task automatic queue_command(input logic [2:0] cmd, input logic [7:0] character,
                                input logic [7:0] column, input logic [7:0] row,
                                input logic [2:0] slot, input logic [31:0] rows_low,
                                input logic [31:0] rows_high);
      lcd_command_type c;
      c.cmd       = cmd;
      c.character = character;
      c.column    = column;
      c.row       = row;
      c.slot      = slot;
      c.rows_low  = rows_low;
      c.rows_high = rows_high;
      pending_cmds.push_back(c);
   endtask

   // mostly character writes so the address walks into the row wraps
   function automatic lcd_command_type random_command();
      lcd_command_type c;
      int pick;
      int sub;
      c.character = 8'($urandom_range(0, 255));
      c.column    = ($urandom_range(0, 1) == 0) ?
                    8'($urandom_range(0, int'(lcd_cfg.visible_columns) + 2)) :
                    8'($urandom_range(0, 255));
      c.row       = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      c.slot      = 3'($urandom_range(0, 7));
      c.rows_low  = $urandom;
      c.rows_high = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         c.cmd = CMD_WRITE;
         sub = $urandom_range(0, 99);
         if (sub < 10)      c.character = CHAR_NEWLINE;
         else if (sub < 15) c.character = CHAR_RETURN;
      end else if (pick < 70) c.cmd = CMD_CURSOR;
      else if (pick < 78)     c.cmd = CMD_GLYPH;
      else if (pick < 84)     c.cmd = CMD_CLEAR;
      else if (pick < 90)     c.cmd = CMD_HOME;
      else if (pick < 94)     c.cmd = CMD_INIT;
      else if (pick < 97)     c.cmd = CMD_RESERVED_6;
      else                    c.cmd = CMD_RESERVED_7;
      return c;
   endfunction

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) pending_cmds.push_back(random_command());
   endtask

   // wait until every command is in and every transfer has come out; a
   // trailing carriage return or reserved code leaves nothing to wait for, so
   // let the pipeline drain before anything touches the csrs
   task automatic wait_idle();
      while (pending_cmds.size() != 0 || req_valid || expected_transfers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all five registers back to back, only ever called while idle
   task automatic apply_settings(input logic [15:0] vis, input logic [15:0] len,
                                 input logic [15:0] start, input logic [15:0] cmd_wait,
                                 input logic [15:0] clr_wait);
      logic [2:0]  idx[5];
      logic [15:0] val[5];
      idx[0] = CSR_VISIBLE_COLUMNS;  val[0] = vis;
      idx[1] = CSR_ROW_LENGTH;       val[1] = len;
      idx[2] = CSR_SECOND_ROW_START; val[2] = start;
      idx[3] = CSR_COMMAND_WAIT;     val[3] = cmd_wait;
      idx[4] = CSR_CLEAR_WAIT;       val[4] = clr_wait;
      for (int i = 0; i < 5; i++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // -------------------------------------------------------------------------
   // command driver: falling edge, fed from pending_cmds
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // payload only moves once the previous transaction went through
         if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            drive_cmd = pending_cmds.pop_front();
            req_valid           <= 1'b1;
            req_command         <= drive_cmd.cmd;
            req_character       <= drive_cmd.character;
            req_column          <= drive_cmd.column;
            req_row             <= drive_cmd.row;
            req_glyph_slot      <= drive_cmd.slot;
            req_glyph_rows_low  <= drive_cmd.rows_low;
            req_glyph_rows_high <= drive_cmd.rows_high;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // transfer stall: random per phase, or a long counted hold-off on request
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_wanted) begin
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // monitor, predictor and watchdog: rising edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      rsp_taken = !reset && rsp_valid && !rsp_stall;
      csr_taken = !reset && csr_valid && csr_ready;

      // compare each transfer with the oldest one expected
      if (rsp_taken) begin
         seen.strobe  = rsp_strobe_res;
         seen.rs      = rsp_register_select;
         seen.nibble  = rsp_nibble;
         seen.wait_us = rsp_wait_after_us;
         seen.last    = rsp_last;
         if (expected_transfers.size() == 0) begin
            report_mismatch("unexpected transfer, nibble", 32'(seen.nibble), 32'd0);
         end else begin
            want = expected_transfers.pop_front();
            if (seen.strobe !== want.strobe)
               report_mismatch("strobe_res", 32'(seen.strobe), 32'(want.strobe));
            if (seen.rs !== want.rs)
               report_mismatch("register_select", 32'(seen.rs), 32'(want.rs));
            if (seen.nibble !== want.nibble)
               report_mismatch("nibble", 32'(seen.nibble), 32'(want.nibble));
            if (seen.wait_us !== want.wait_us)
               report_mismatch("wait_after_us", 32'(seen.wait_us), 32'(want.wait_us));
            if (seen.last !== want.last)
               report_mismatch("last", 32'(seen.last), 32'(want.last));
         end
         transfers_checked++;
      end

      // accepted command: expand it against the shadow state
      if (req_taken) begin
         taken_cmd.cmd       = req_command;
         taken_cmd.character = req_character;
         taken_cmd.column    = req_column;
         taken_cmd.row       = req_row;
         taken_cmd.slot      = req_glyph_slot;
         taken_cmd.rows_low  = req_glyph_rows_low;
         taken_cmd.rows_high = req_glyph_rows_high;
         expand_command(taken_cmd);
         cmd_count[req_command]++;
      end

      // register write: keep the shadow copy in step
      if (csr_taken) begin
         case (csr_index)
            CSR_VISIBLE_COLUMNS:  lcd_cfg.visible_columns  = csr_data[5:0];
            CSR_ROW_LENGTH:       lcd_cfg.row_length       = csr_data[6:0];
            CSR_SECOND_ROW_START: lcd_cfg.second_row_start = csr_data[6:0];
            CSR_COMMAND_WAIT:     lcd_cfg.command_wait_us  = csr_data;
            CSR_CLEAR_WAIT:       lcd_cfg.clear_wait_us    = csr_data;
            default: ;
         endcase
      end

      // watchdog on cycles where no channel moved a transaction
      if (req_taken || rsp_taken || csr_taken || reset) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < 8; i++) cmd_count[i] = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles lightly, receiver heavily
      send_idle_pct = 27;
      recv_idle_pct = 80;

      // reset-value settings written explicitly, then the directed commands
      apply_settings(16'd16, 16'd40, 16'd64, 16'd50, 16'd2000);
      queue_command(CMD_INIT,   8'h00, 8'h00, 8'h00, 3'd0, 32'h0, 32'h0);
      queue_command(CMD_WRITE,  8'h00, 8'h00, 8'h00, 3'd0, 32'h0, 32'h0);
      queue_command(CMD_WRITE,  8'hFF, 8'hFF, 8'hFF, 3'd7, '1, '1);
      // newline from row zero, then back from row one
      queue_command(CMD_WRITE,  CHAR_NEWLINE, 8'h00, 8'h00, 3'd0, 32'h0, 32'h0);
      queue_command(CMD_WRITE,  CHAR_NEWLINE, 8'h00, 8'h00, 3'd0, 32'h0, 32'h0);
      // carriage return gives no transfer
      queue_command(CMD_WRITE,  CHAR_RETURN, 8'h00, 8'h00, 3'd0, 32'h0, 32'h0);
      queue_command(CMD_WRITE,  8'h41, 8'h00, 8'h00, 3'd0, 32'h0, 32'h0);
      queue_command(CMD_CLEAR,  8'h00, 8'h00, 8'h00, 3'd0, 32'h0, 32'h0);
      queue_command(CMD_HOME,   8'h00, 8'h00, 8'h00, 3'd0, 32'h0, 32'h0);
      queue_command(CMD_CURSOR, 8'h00, 8'h00, 8'h00, 3'd0, 32'h0, 32'h0);
      // column far past the screen, row at its maximum
      queue_command(CMD_CURSOR, 8'h00, 8'hFF, 8'hFF, 3'd0, 32'h0, 32'h0);
      queue_command(CMD_CURSOR, 8'h00, 8'd15, 8'd1, 3'd0, 32'h0, 32'h0);
      queue_command(CMD_CURSOR, 8'h00, 8'd16, 8'd0, 3'd0, 32'h0, 32'h0);
      queue_command(CMD_GLYPH,  8'h00, 8'h00, 8'h00, 3'd0, 32'h0, 32'h0);
      queue_command(CMD_GLYPH,  8'h00, 8'h00, 8'h00, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_command(CMD_GLYPH,  8'h00, 8'h00, 8'h00, 3'd5, 32'h1F11_0A04, 32'h0E15_1B00);
      // reserved codes are dropped without touching the address
      queue_command(CMD_RESERVED_6, 8'h55, 8'h22, 8'h01, 3'd2, 32'h0, 32'h0);
      queue_command(CMD_RESERVED_7, 8'hAA, 8'h11, 8'h00, 3'd6, 32'h0, 32'h0);
      queue_command(CMD_WRITE,  8'h7E, 8'h00, 8'h00, 3'd0, 32'h0, 32'h0);
      queue_command(CMD_INIT,   8'hFF, 8'hFF, 8'hFF, 3'd7, '1, '1);
      wait_idle();

      // forty visible columns, 64-character rows, row one at the top of memory, longest waits
      apply_settings(16'd40, 16'd64, 16'd127, 16'hFFFF, 16'hFFFF);
      queue_random(50);
      wait_idle();

      // roles swap: sender idles heavily, receiver lightly
      send_idle_pct = 80;
      recv_idle_pct = 27;

      // zero columns, single-character rows, both rows at address zero, no waits
      apply_settings(16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
      queue_random(50);
      wait_idle();

      // anything the register widths allow
      apply_settings(16'($urandom_range(0, 63)), 16'($urandom_range(0, 127)),
                     16'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)));
      queue_random(50);
      wait_idle();

      // no idling at all, short rows so writes wrap often
      send_idle_pct = 0;
      recv_idle_pct = 0;
      apply_settings(16'd8, 16'd8, 16'd40, 16'd37, 16'd1520);
      // receiver holds off while commands keep coming, so req_stall must rise
      @(posedge clock);
      hold_wanted++;
      queue_random(50);
      wait_idle();

      if (expected_transfers.size() != 0)
         report_mismatch("transfers never seen", 32'(expected_transfers.size()), 32'd0);

      $display("commands: init %0d, write %0d, clear %0d, home %0d, cursor %0d,",
               cmd_count[CMD_INIT], cmd_count[CMD_WRITE], cmd_count[CMD_CLEAR],
               cmd_count[CMD_HOME], cmd_count[CMD_CURSOR]);
      $display("          glyph %0d, reserved %0d",
               cmd_count[CMD_GLYPH], cmd_count[CMD_RESERVED_6] + cmd_count[CMD_RESERVED_7]);
      $display("%0d transfers checked over %0d register settings, %0d mismatches",
               transfers_checked, settings_used, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
